>>> sv/rotated_mono_framebuffer_draw_core_defines.svh
// ---------------------------------------------------------------------------
// rotated_mono_framebuffer_draw_core_defines
// assertion macros shared by the draw core
// ---------------------------------------------------------------------------
`ifndef ROTATED_MONO_FRAMEBUFFER_DRAW_CORE_DEFINES_SVH
`define ROTATED_MONO_FRAMEBUFFER_DRAW_CORE_DEFINES_SVH

// same-cycle implication
`define RMFB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmfb assertion failed");

// next-cycle implication
`define RMFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmfb assertion failed");

`endif

>>> sv/rmfb_pkg.sv
// ---------------------------------------------------------------------------
// rmfb_pkg
// types, command codes and font table of the rotated frame buffer core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmfb_pkg;

  localparam int CW    = 12;
  localparam int ACC_W = 14;

  localparam logic [7:0] CHAR_LOW_A    = 8'd97;
  localparam logic [7:0] CHAR_LOW_Z    = 8'd122;
  localparam logic [7:0] CHAR_CASE_OFS = 8'd32;
  localparam logic [7:0] GLYPH_FIRST   = 8'd32;
  localparam logic [7:0] GLYPH_LAST    = 8'd95;
  localparam logic [7:0] GLYPH_FALLBK  = 8'd63;
  localparam logic [2:0] GLYPH_COL_END = 3'd4;
  localparam logic [2:0] GLYPH_ROW_END = 3'd6;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_PIXEL = 3'd1,
    CMD_LINE  = 3'd2,
    CMD_READ  = 3'd3,
    CMD_GLYPH = 3'd4
  } cmd_code_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_PIXEL,
    ST_LINE,
    ST_GLYPH,
    ST_READ,
    ST_RD_WAIT,
    ST_FINISH
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic pix_step;
    logic line_step;
    logic glyph_step;
    logic rd_issue;
    logic rd_capture;
    logic out_load;
  } dp_ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic line_last;
    logic glyph_last;
  } dp_stat_t;

  // column i of a glyph sits in bits [8*i +: 7], bit b is row b
  localparam logic [39:0] FONT [64] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
    40'h0041221C00, 40'h001C224100, 40'h082A1C2A08, 40'h08083E0808,
    40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
    40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
    40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
    40'h3649494936, 40'h1E29494906, 40'h0000363600, 40'h0000365600,
    40'h4122140800, 40'h1414141414, 40'h0008142241, 40'h0609510102,
    40'h3E41794932, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
    40'h1C2241417F, 40'h414949497F, 40'h010909097F, 40'h7A4949413E,
    40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
    40'h404040407F, 40'h7F020C027F, 40'h7F1008047F, 40'h3E4141413E,
    40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3149494946,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h4345495161, 40'h0041417F00,
    40'h2010080402, 40'h007F414100, 40'h0402010204, 40'h4040404040
  };

endpackage

>>> sv/rmfb_ctrl.sv
// ---------------------------------------------------------------------------
// rmfb_ctrl
// command sequencer of the frame buffer draw core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmfb_ctrl
  import rmfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_ctrl_t   ctrl,
  input  dp_stat_t   stat
);

  fsm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    ctrl          = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_INIT: begin
        ctrl.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          case (in_cmd)
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_PIXEL: state_nxt = ST_PIXEL;
            CMD_LINE:  state_nxt = ST_LINE;
            CMD_READ:  state_nxt = ST_READ;
            CMD_GLYPH: state_nxt = ST_GLYPH;
            default:   state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_CLEAR: begin
        ctrl.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_FINISH;
      end
      ST_PIXEL: begin
        ctrl.pix_step = 1'b1;
        state_nxt     = ST_FINISH;
      end
      ST_LINE: begin
        ctrl.line_step = 1'b1;
        if (stat.line_last) state_nxt = ST_FINISH;
      end
      ST_GLYPH: begin
        ctrl.glyph_step = 1'b1;
        if (stat.glyph_last) state_nxt = ST_FINISH;
      end
      ST_READ: begin
        ctrl.rd_issue = 1'b1;
        state_nxt     = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        ctrl.rd_capture = 1'b1;
        state_nxt       = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          ctrl.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/rmfb_datapath.sv
// ---------------------------------------------------------------------------
// rmfb_datapath
// frame store, line walker, glyph scanner and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmfb_datapath
  import rmfb_pkg::*;
#(
  parameter int PANEL_LONG  = 160,
  parameter int PANEL_SHORT = 68
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        in_cmd,
  input  logic signed [9:0] in_start_x,
  input  logic signed [9:0] in_start_y,
  input  logic signed [9:0] in_end_x,
  input  logic signed [9:0] in_end_y,
  input  logic              in_pixel_on,
  input  logic [7:0]        in_char_code,
  input  dp_ctrl_t          ctrl,
  output dp_stat_t          stat,
  output logic              out_read_value,
  output logic [2:0]        out_command_done
);

  localparam int DEPTH = PANEL_LONG * PANEL_SHORT;
  localparam int AW    = $clog2(DEPTH);

  logic [2:0]              cmd_r;
  logic signed [CW-1:0]    cx_r, cy_r, ex_r, ey_r;
  logic signed [ACC_W-1:0] dx_r, dy_r, acc_r;
  logic                    stx_r, sty_r, on_r;
  logic [5:0]              gidx_r;
  logic [2:0]              gcol_r, grow_r;
  logic [AW-1:0]           clr_cnt_r;
  logic                    mem [DEPTH];
  logic                    mem_rd_r, rd_on_r, rv_r;
  logic                    out_rv_r;
  logic [2:0]              out_cmd_r;

  logic signed [CW-1:0]    sx, sy, ex, ey, adx, ady;
  logic signed [ACC_W-1:0] dx, dy, twice, acc_nxt;
  logic                    cstep_x, cstep_y;
  logic [7:0]              code;
  logic signed [CW-1:0]    px, py;
  logic                    on_panel, fbit;
  logic [5:0]              fbit_idx;
  logic [AW-1:0]           xu, yu, addr, waddr;
  logic                    we, wdata;

  // load side
  always_comb begin
    sx  = {{(CW-10){in_start_x[9]}}, in_start_x};
    sy  = {{(CW-10){in_start_y[9]}}, in_start_y};
    ex  = {{(CW-10){in_end_x[9]}}, in_end_x};
    ey  = {{(CW-10){in_end_y[9]}}, in_end_y};
    adx = (ex > sx) ? ex - sx : sx - ex;
    ady = (ey > sy) ? ey - sy : sy - ey;
    dx  = {{(ACC_W-CW){adx[CW-1]}}, adx};
    dy  = -{{(ACC_W-CW){ady[CW-1]}}, ady};
    code = in_char_code;
    if (code >= CHAR_LOW_A && code <= CHAR_LOW_Z) code = code - CHAR_CASE_OFS;
    if (code < GLYPH_FIRST || code > GLYPH_LAST) code = GLYPH_FALLBK;
  end

  // bresenham step
  always_comb begin
    twice   = acc_r <<< 1;
    cstep_x = (twice >= dy_r);
    cstep_y = (twice <= dx_r);
    acc_nxt = acc_r + (cstep_x ? dy_r : '0) + (cstep_y ? dx_r : '0);
  end

  // pixel address
  always_comb begin
    px       = cx_r + $signed({{(CW-3){1'b0}}, gcol_r});
    py       = cy_r + $signed({{(CW-3){1'b0}}, grow_r});
    on_panel = (px >= 0) && (py >= 0) &&
               (px < $signed(CW'(PANEL_SHORT))) && (py < $signed(CW'(PANEL_LONG)));
    fbit_idx = {gcol_r, 3'b000} + {3'b000, grow_r};
    fbit     = FONT[gidx_r][fbit_idx];
    xu       = AW'(unsigned'(px));
    yu       = AW'(unsigned'(py));
    addr     = AW'(xu * AW'(PANEL_LONG)) + AW'(PANEL_LONG - 1) - yu;
    we       = ctrl.clr_step | ((ctrl.pix_step | ctrl.line_step) & on_panel) |
               (ctrl.glyph_step & on_panel & fbit);
    waddr    = ctrl.clr_step ? clr_cnt_r : addr;
    wdata    = ctrl.clr_step ? 1'b0 : (ctrl.line_step ? 1'b1 : on_r);
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    mem_rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      gcol_r    <= '0;
      grow_r    <= '0;
    end else begin
      if (ctrl.clr_step) begin
        clr_cnt_r <= stat.clr_last ? '0 : clr_cnt_r + 1'b1;
      end
      if (ctrl.load) begin
        gcol_r <= '0;
        grow_r <= '0;
      end else if (ctrl.glyph_step) begin
        if (grow_r == GLYPH_ROW_END) begin
          grow_r <= '0;
          gcol_r <= (gcol_r == GLYPH_COL_END) ? '0 : gcol_r + 1'b1;
        end else begin
          grow_r <= grow_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r  <= in_cmd;
      cx_r   <= sx;
      cy_r   <= sy;
      ex_r   <= ex;
      ey_r   <= ey;
      dx_r   <= dx;
      dy_r   <= dy;
      acc_r  <= dx + dy;
      stx_r  <= !(sx < ex);
      sty_r  <= !(sy < ey);
      on_r   <= in_pixel_on;
      gidx_r <= 6'(code - GLYPH_FIRST);
      rv_r   <= 1'b0;
    end else begin
      if (ctrl.line_step) begin
        acc_r <= acc_nxt;
        if (cstep_x) cx_r <= stx_r ? cx_r - 1'b1 : cx_r + 1'b1;
        if (cstep_y) cy_r <= sty_r ? cy_r - 1'b1 : cy_r + 1'b1;
      end
      if (ctrl.rd_capture) rv_r <= rd_on_r & mem_rd_r;
    end
    if (ctrl.rd_issue) rd_on_r <= on_panel;
    if (ctrl.out_load) begin
      out_rv_r  <= rv_r;
      out_cmd_r <= cmd_r;
    end
  end

  assign stat.clr_last   = (clr_cnt_r == AW'(DEPTH - 1));
  assign stat.line_last  = (cx_r == ex_r) && (cy_r == ey_r);
  assign stat.glyph_last = (gcol_r == GLYPH_COL_END) && (grow_r == GLYPH_ROW_END);

  assign out_read_value   = out_rv_r;
  assign out_command_done = out_cmd_r;

endmodule

>>> sv/rotated_mono_framebuffer_draw_core.sv
// ---------------------------------------------------------------------------
// rotated_mono_framebuffer_draw_core
// portrait 1-bit frame buffer with clear, pixel, line, glyph and read
// ---------------------------------------------------------------------------
// a command goes from IDLE through its own state (READ then RD_WAIT for a read) to FINISH
// one command at a time; the frame store has one write port and takes one pixel a cycle
// a line walks one pixel per cycle through the shared store port
// after reset a clearing pass over all L*S cells (10880 at default) runs first
// reset is synchronous active low and leaves the store all paper
`timescale 1ns / 1ps

`include "rotated_mono_framebuffer_draw_core_defines.svh"

module rotated_mono_framebuffer_draw_core
  import rmfb_pkg::*;
#(
  parameter int PANEL_LONG  = 160,
  parameter int PANEL_SHORT = 68
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_cmd,
  input  logic signed [9:0] in_start_x,
  input  logic signed [9:0] in_start_y,
  input  logic signed [9:0] in_end_x,
  input  logic signed [9:0] in_end_y,
  input  logic              in_pixel_on,
  input  logic [7:0]        in_char_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_read_value,
  output logic [2:0]        out_command_done
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  rmfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  rmfb_datapath #(
    .PANEL_LONG  (PANEL_LONG),
    .PANEL_SHORT (PANEL_SHORT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_cmd),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_pixel_on      (in_pixel_on),
    .in_char_code     (in_char_code),
    .ctrl             (ctrl),
    .stat             (stat),
    .out_read_value   (out_read_value),
    .out_command_done (out_command_done)
  );

  `RMFB_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready)
  `RMFB_ASSERT_IMPL(a_read_value_only_on_read, out_valid && (out_command_done != CMD_READ), !out_read_value)
  `RMFB_ASSERT_IMPL(a_no_step_while_idle, in_ready, !(ctrl.clr_step || ctrl.line_step || ctrl.glyph_step))

endmodule

>>> tb/sv/tb_rotated_mono_framebuffer_draw_core.sv
// ---------------------------------------------------------------------------
// tb_rotated_mono_framebuffer_draw_core
// checks clear, pixel, line, glyph and read commands against a portrait
// frame store kept in the bench, with random gaps on both channels
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rotated_mono_framebuffer_draw_core;
  import rmfb_pkg::*;

  localparam int LONG_SIDE  = 160;
  localparam int SHORT_SIDE = 68;
  localparam int IDLE_LIMIT = 60000;

  typedef struct packed {
    logic       rd;
    logic [2:0] done;
  } beat_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        in_cmd = '0;
  logic signed [9:0] in_start_x = '0;
  logic signed [9:0] in_start_y = '0;
  logic signed [9:0] in_end_x = '0;
  logic signed [9:0] in_end_y = '0;
  logic              in_pixel_on = 1'b0;
  logic [7:0]        in_char_code = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_read_value;
  logic [2:0]        out_command_done;

  logic         panel [LONG_SIDE*SHORT_SIDE];
  beat_result_t expected_results [$];
  int           idle_cycles = 0;
  int           out_wait = 0;
  bit           failed = 1'b0;

  always #1 clk = ~clk;

  rotated_mono_framebuffer_draw_core dut (.*);

  function automatic bit on_panel(int x, int y);
    return x >= 0 && y >= 0 && x < SHORT_SIDE && y < LONG_SIDE;
  endfunction

  function automatic void plot(int x, int y, logic v);
    if (on_panel(x, y)) panel[x*LONG_SIDE + (LONG_SIDE-1-y)] = v;
  endfunction

  function automatic void wipe_panel();
    foreach (panel[i]) panel[i] = 1'b0;
  endfunction

  function automatic void trace_line(int ax, int ay, int bx, int by);
    int dx, dy, sx, sy, acc, dbl;
    dx = (bx > ax) ? bx - ax : ax - bx;
    dy = (by > ay) ? ay - by : by - ay;
    sx = (ax < bx) ? 1 : -1;
    sy = (ay < by) ? 1 : -1;
    acc = dx + dy;
    forever begin
      plot(ax, ay, 1'b1);
      if (ax == bx && ay == by) break;
      dbl = 2 * acc;
      if (dbl >= dy) begin
        acc += dy;
        ax += sx;
      end
      if (dbl <= dx) begin
        acc += dx;
        ay += sy;
      end
    end
  endfunction

  function automatic void stamp_glyph(logic [7:0] code, int x, int y, logic v);
    logic [7:0] c;
    logic [39:0] bits;
    c = code;
    if (c >= 8'd97 && c <= 8'd122) c = c - 8'd32;
    if (c < 8'd32 || c > 8'd95) c = 8'd63;
    bits = FONT[c - 8'd32];
    for (int i = 0; i < 5; i++)
      for (int b = 0; b < 7; b++)
        if (bits[8*i + b]) plot(x + i, y + b, v);
  endfunction

  function automatic beat_result_t apply_command(logic [2:0] cmd, int sx, int sy, int ex,
                                                 int ey, logic on, logic [7:0] code);
    beat_result_t r;
    r.rd = 1'b0;
    r.done = cmd;
    case (cmd)
      CMD_CLEAR: wipe_panel();
      CMD_PIXEL: plot(sx, sy, on);
      CMD_LINE:  trace_line(sx, sy, ex, ey);
      CMD_READ:  r.rd = on_panel(sx, sy) ? panel[sx*LONG_SIDE + (LONG_SIDE-1-sy)] : 1'b0;
      CMD_GLYPH: stamp_glyph(code, sx, sy, on);
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_command(logic [2:0] cmd, int sx, int sy, int ex, int ey,
                              logic on, logic [7:0] code);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_start_x <= sx[9:0];
    in_start_y <= sy[9:0];
    in_end_x <= ex[9:0];
    in_end_y <= ey[9:0];
    in_pixel_on <= on;
    in_char_code <= code;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(apply_command(cmd, $signed(sx[9:0]), $signed(sy[9:0]),
                                             $signed(ex[9:0]), $signed(ey[9:0]), on, code));
  endtask

  function automatic int near_x();
    return $urandom_range(0, 3) == 0 ? $signed(10'($urandom)) : int'($urandom_range(0, 75)) - 4;
  endfunction

  function automatic int near_y();
    return $urandom_range(0, 3) == 0 ? $signed(10'($urandom)) : int'($urandom_range(0, 167)) - 4;
  endfunction

  task automatic test_pixels();
    send_command(CMD_PIXEL, 0, 0, 0, 0, 1'b1, 8'd0);
    send_command(CMD_READ, 0, 0, 0, 0, 1'b0, 8'd0);
    send_command(CMD_PIXEL, 67, 159, 0, 0, 1'b1, 8'd0);
    send_command(CMD_READ, 67, 159, 0, 0, 1'b0, 8'd0);
    send_command(CMD_PIXEL, 68, 160, 0, 0, 1'b1, 8'd0);
    send_command(CMD_READ, 68, 160, 0, 0, 1'b0, 8'd0);
    send_command(CMD_PIXEL, -512, 511, 0, 0, 1'b1, 8'd0);
    send_command(CMD_READ, -1, -1, 0, 0, 1'b0, 8'd0);
    send_command(CMD_PIXEL, 0, 0, 0, 0, 1'b0, 8'd0);
    send_command(CMD_READ, 0, 0, 0, 0, 1'b0, 8'd0);
  endtask

  task automatic test_lines();
    send_command(CMD_LINE, -10, -10, 80, 170, 1'b0, 8'd0);
    send_command(CMD_LINE, 67, 0, 0, 159, 1'b0, 8'd0);
    send_command(CMD_LINE, 5, 5, 5, 5, 1'b0, 8'd0);
    send_command(CMD_LINE, 30, 20, 10, 22, 1'b0, 8'd0);
    send_command(CMD_READ, 67, 0, 0, 0, 1'b0, 8'd0);
  endtask

  task automatic test_glyphs();
    send_command(CMD_GLYPH, 0, 0, 0, 0, 1'b1, 8'd65);
    send_command(CMD_GLYPH, 64, 155, 0, 0, 1'b1, 8'd97);
    send_command(CMD_GLYPH, 20, 40, 0, 0, 1'b1, 8'd255);
    send_command(CMD_GLYPH, 20, 40, 0, 0, 1'b0, 8'd0);
    send_command(CMD_GLYPH, -2, -3, 0, 0, 1'b1, 8'd95);
    send_command(CMD_READ, 1, 0, 0, 0, 1'b0, 8'd0);
  endtask

  task automatic test_unused_and_clear();
    send_command(3'd5, 1, 1, 0, 0, 1'b1, 8'd0);
    send_command(3'd7, 1, 1, 0, 0, 1'b1, 8'd0);
    send_command(CMD_CLEAR, 0, 0, 0, 0, 1'b1, 8'd0);
    send_command(CMD_READ, 0, 0, 0, 0, 1'b0, 8'd0);
  endtask

  task automatic test_random();
    logic [2:0] cmd;
    int         pick;
    int         sx, sy;
    for (int n = 0; n < 450; n++) begin
      pick = $urandom_range(0, 99);
      cmd = pick < 2 ? CMD_CLEAR : pick < 30 ? CMD_PIXEL : pick < 45 ? CMD_LINE :
            pick < 80 ? CMD_READ : pick < 95 ? CMD_GLYPH : 3'($urandom_range(5, 7));
      sx = near_x();
      sy = near_y();
      if (cmd == CMD_LINE && $urandom_range(0, 3) != 0)
        send_command(cmd, sx, sy, sx + int'($urandom_range(0, 40)) - 20,
                     sy + int'($urandom_range(0, 40)) - 20, 1'($urandom), 8'($urandom));
      else
        send_command(cmd, sx, sy, near_x(), near_y(), 1'($urandom), 8'($urandom));
    end
  endtask

  always @(posedge clk) begin
    int w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected beat cmd %0d", out_command_done);
          failed <= 1'b1;
        end else begin
          beat_result_t e;
          e = expected_results.pop_front();
          if (out_read_value !== e.rd) begin
            $error("read_value exp %0d got %0d", e.rd, out_read_value);
            failed <= 1'b1;
          end
          if (out_command_done !== e.done) begin
            $error("command_done exp %0d got %0d", e.done, out_command_done);
            failed <= 1'b1;
          end
        end
        w = $urandom_range(0, 16);
        out_wait <= w;
        out_ready <= (w == 0);
      end else if (out_valid && !out_ready) begin
        if (out_wait == 0) out_ready <= 1'b1;
        else out_wait <= out_wait - 1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    wipe_panel();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_pixels();
    test_lines();
    test_glyphs();
    test_unused_and_clear();
    test_random();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/rmfb_pkg.sv
sv/rmfb_ctrl.sv
sv/rmfb_datapath.sv
sv/rotated_mono_framebuffer_draw_core.sv
tb/sv/tb_rotated_mono_framebuffer_draw_core.sv
